### rtl/hhyo_pkg.sv
package hhyo_pkg;

  localparam int TIME_W = 48;
  localparam int ANG_W  = 17;
  localparam int HDG_W  = 16;
  localparam int ACC_W  = 19;
  localparam int ARC_W  = 15;
  localparam int THR_W  = 16;

  localparam logic [ACC_W-1:0] FULL_TURN = ACC_W'(36000);
  localparam logic [ACC_W-1:0] HALF_TURN = ACC_W'(18000);
  // four turns lift any sum of two 17-bit angles above zero
  localparam logic signed [ACC_W:0] BIAS = (ACC_W+1)'(144000);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(20);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_RED,
    ST_REC_WR,
    ST_Q_FETCH,
    ST_Q_CHK,
    ST_A_FETCH,
    ST_A_CHK,
    ST_DIV,
    ST_HDG_RED,
    ST_OFF_RED,
    ST_EMIT
  } state_t;

  // yaw plus gimbal yaw, biased positive
  function automatic logic [ACC_W-1:0] rec_base(logic [ANG_W-1:0] a, logic [ANG_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'($signed(a)) + (ACC_W+1)'($signed(b)) + BIAS;
    return s[ACC_W-1:0];
  endfunction

  // measured yaw minus heading, biased positive
  function automatic logic [ACC_W-1:0] off_base(logic [ANG_W-1:0] a, logic [HDG_W-1:0] h);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'($signed(a)) - $signed({4'b0, h}) + BIAS;
    return s[ACC_W-1:0];
  endfunction

endpackage

### rtl/hhyo_ram.sv
module hhyo_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, read one entry with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/hhyo_div.sv
module hhyo_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [hhyo_pkg::TIME_W-1:0] lag,
  input  logic [hhyo_pkg::ARC_W-1:0]  arc,
  input  logic [hhyo_pkg::TIME_W-1:0] span,
  output logic                  done,
  output logic [hhyo_pkg::ARC_W-1:0]  quot
);
  import hhyo_pkg::*;

  localparam int PROD_W = TIME_W + ARC_W;

  logic [TIME_W-1:0] op_lag;
  logic [TIME_W-1:0] op_span;
  logic [ARC_W-1:0]  op_arc;
  logic              mul_pend;
  logic              run;
  logic [4:0]        cnt;
  logic [TIME_W-1:0] rem;
  logic [ARC_W-1:0]  low;
  logic [PROD_W-1:0] prod;
  logic [TIME_W:0]   trial;
  logic              fits;

  assign prod  = op_lag * op_arc;
  assign trial = {rem, low[ARC_W-1]};
  assign fits  = trial >= {1'b0, op_span};

  // multiply once, then one quotient bit per cycle; quotient stays below 2^15
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_pend <= 1'b0;
      run      <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        op_lag   <= lag;
        op_arc   <= arc;
        op_span  <= span;
        mul_pend <= 1'b1;
      end else if (mul_pend) begin
        rem      <= prod[PROD_W-1:ARC_W];
        low      <= prod[ARC_W-1:0];
        quot     <= '0;
        cnt      <= 5'(ARC_W);
        mul_pend <= 1'b0;
        run      <= 1'b1;
      end else if (run) begin
        rem  <= fits ? TIME_W'(trial - {1'b0, op_span}) : trial[TIME_W-1:0];
        low  <= {low[ARC_W-2:0], 1'b0};
        quot <= {quot[ARC_W-2:0], fits};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/heading_history_yaw_offset_core.sv
// Heading history and yaw offset.
// Input channel (in_valid/in_ready): mode 0 records time_ms with the camera
// heading (yaw_cdeg + gimbal_yaw_cdeg wrapped into [0,36000)); mode 1 queries
// the offset of yaw_cdeg from the heading valid at time_ms.
// Output channel (out_valid/out_ready): one item per answered query, carrying
// query_time_ms and offset_cdeg in (-18000,18000]. Records and queries that
// arrive before the first record give no output item.
// The block handles one item at a time. A query reads one memory entry per
// history slot visited by the backward walk, may then run the interpolation
// divider (one multiply, then 15 quotient bits) and ends with angle wrapping.
// A finished result sits in an output register; the next item is taken while
// it waits, and a later query holds in its final state until the register
// frees up. A stalled receiver therefore stalls input only after one query.
// Reset (rst, synchronous) empties the history logically through a fill
// mark, with no clearing pass, and sets interp_threshold_ms to 20. cfg_we
// writes interp_threshold_ms from cfg_wdata; the user must do so only while
// the block is idle, which the block itself does not enforce.
module heading_history_yaw_offset_core #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [hhyo_pkg::THR_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [hhyo_pkg::TIME_W-1:0]  time_ms,
  input  logic signed [hhyo_pkg::ANG_W-1:0] yaw_cdeg,
  input  logic signed [hhyo_pkg::ANG_W-1:0] gimbal_yaw_cdeg,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hhyo_pkg::TIME_W-1:0]  query_time_ms,
  output logic signed [hhyo_pkg::HDG_W-1:0] offset_cdeg
);
  import hhyo_pkg::*;

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int ENT_W  = HDG_W + TIME_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);

  state_t state, state_next;

  logic [THR_W-1:0]  thr;
  logic [SLOT_W-1:0] newest;
  logic              started;
  logic              wrapped;
  logic [TIME_W-1:0] q_time;
  logic [ANG_W-1:0]  yaw;
  logic [ACC_W-1:0]  acc;
  logic [SLOT_W-1:0] idx;
  logic              first;
  logic [HDG_W-1:0]  h_before;
  logic [TIME_W-1:0] t_before;
  logic [TIME_W-1:0] lag;
  logic              fwd;

  logic [SLOT_W-1:0] idx_prev, idx_nxt, new_nxt, wslot, raddr;
  logic              ram_we;
  logic [ENT_W-1:0]  rdata;
  logic [TIME_W-1:0] rd_time, tm;
  logic [HDG_W-1:0]  rd_hdg;
  logic              slot_ok;
  logic [TIME_W:0]   lag_c, span_c;
  logic              lag_hit;
  logic              span_ok;
  logic signed [HDG_W:0] arc_d;
  logic [ACC_W-1:0]  arc_w;
  logic [ARC_W-1:0]  arc_mag;
  logic              arc_fwd;
  logic              div_start;
  logic              div_done;
  logic [ARC_W-1:0]  quot;
  logic              acc_big;
  logic              out_free;

  // ring stepping
  assign idx_prev = (idx == '0) ? LAST_SLOT : idx - 1'b1;
  assign idx_nxt  = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
  assign new_nxt  = (newest == LAST_SLOT) ? '0 : newest + 1'b1;
  assign wslot    = started ? new_nxt : SLOT_W'(1);

  // slots past the fill mark read as empty
  assign slot_ok = wrapped || (idx != '0 && idx <= newest);
  assign rd_time = rdata[TIME_W-1:0];
  assign rd_hdg  = rdata[ENT_W-1:TIME_W];
  assign tm      = slot_ok ? rd_time : '0;
  assign lag_c   = {1'b0, q_time} - {1'b0, tm};
  assign lag_hit = !lag_c[TIME_W] && lag_c != '0 && lag_c[TIME_W-1:0] >= TIME_W'(thr);

  // span and shorter arc toward the later sample
  assign span_c  = {1'b0, rd_time} - {1'b0, t_before};
  assign span_ok = !span_c[TIME_W] && span_c != '0 && lag <= span_c[TIME_W-1:0];
  assign arc_d   = $signed({1'b0, rd_hdg}) - $signed({1'b0, h_before});
  assign arc_w   = arc_d[HDG_W] ? ACC_W'(arc_d) + FULL_TURN : ACC_W'(arc_d);
  assign arc_fwd = arc_w <= HALF_TURN;
  assign arc_mag = arc_fwd ? arc_w[ARC_W-1:0] : ARC_W'(FULL_TURN - arc_w);

  assign acc_big  = acc >= FULL_TURN;
  assign out_free = !out_valid || out_ready;
  assign in_ready = state == ST_IDLE;

  hhyo_ram #(
    .WIDTH(ENT_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wslot),
    .wdata({acc[HDG_W-1:0], q_time}),
    .raddr(raddr),
    .rdata(rdata)
  );

  hhyo_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .lag  (lag),
    .arc  (arc_mag),
    .span (span_c[TIME_W-1:0]),
    .done (div_done),
    .quot (quot)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    raddr      = idx;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!mode) begin
            state_next = ST_REC_RED;
          end else if (started) begin
            state_next = ST_Q_FETCH;
          end
        end
      end
      ST_REC_RED: if (!acc_big) state_next = ST_REC_WR;
      ST_REC_WR: begin
        ram_we     = 1'b1;
        state_next = ST_IDLE;
      end
      ST_Q_FETCH: state_next = ST_Q_CHK;
      ST_Q_CHK: begin
        if (first) begin
          state_next = lag_c[TIME_W] ? ST_Q_FETCH : ST_OFF_RED;
        end else if (tm == '0) begin
          state_next = ST_OFF_RED;
        end else if (!lag_c[TIME_W]) begin
          state_next = lag_hit ? ST_A_FETCH : ST_OFF_RED;
        end else begin
          state_next = (idx == new_nxt) ? ST_OFF_RED : ST_Q_FETCH;
        end
      end
      ST_A_FETCH: begin
        raddr      = idx_nxt;
        state_next = ST_A_CHK;
      end
      ST_A_CHK: begin
        div_start  = span_ok;
        state_next = span_ok ? ST_DIV : ST_OFF_RED;
      end
      ST_DIV: if (div_done) state_next = ST_HDG_RED;
      ST_HDG_RED: if (!acc_big) state_next = ST_OFF_RED;
      ST_OFF_RED: if (!acc_big) state_next = ST_EMIT;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // history bookkeeping and threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr     <= THR_RESET;
      newest  <= '0;
      started <= 1'b0;
      wrapped <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr <= cfg_wdata;
      end
      if (state == ST_REC_WR) begin
        newest  <= wslot;
        started <= 1'b1;
        if (wslot == '0) begin
          wrapped <= 1'b1;
        end
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        q_time <= time_ms;
        yaw    <= yaw_cdeg;
        acc    <= rec_base(yaw_cdeg, gimbal_yaw_cdeg);
        idx    <= newest;
        first  <= 1'b1;
      end
      ST_REC_RED, ST_HDG_RED: begin
        if (acc_big) begin
          acc <= acc - FULL_TURN;
        end else if (state == ST_HDG_RED) begin
          acc <= off_base(yaw, acc[HDG_W-1:0]);
        end
      end
      ST_Q_CHK: begin
        first <= 1'b0;
        if (first || tm != '0) begin
          h_before <= rd_hdg;
          t_before <= tm;
          lag      <= lag_c[TIME_W-1:0];
          acc      <= off_base(yaw, rd_hdg);
        end else begin
          acc <= off_base(yaw, h_before);
        end
        idx <= idx_prev;
        if (!first && tm != '0 && !lag_c[TIME_W]) begin
          idx <= idx;
        end
      end
      ST_A_CHK: fwd <= arc_fwd;
      ST_DIV: begin
        if (div_done) begin
          acc <= fwd ? ACC_W'(h_before) + FULL_TURN + ACC_W'(quot)
                     : ACC_W'(h_before) + FULL_TURN - ACC_W'(quot);
        end
      end
      ST_OFF_RED: if (acc_big) acc <= acc - FULL_TURN;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid     <= 1'b1;
      query_time_ms <= q_time;
      offset_cdeg   <= (acc > HALF_TURN) ? HDG_W'(acc - FULL_TURN) : HDG_W'(acc);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/hhyo_checker.sv
module hhyo_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic mode,
  input logic out_valid,
  input logic out_ready
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a record never produces a result
  a_rec_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !mode |=> !$rose(out_valid))
    else $error("result appeared after a record");

  // a record keeps the block busy for its write
  a_rec_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !mode |=> !in_ready)
    else $error("input taken during record write");

  // ready for an item right after reset
  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("not ready after reset");

endmodule

bind heading_history_yaw_offset_core hhyo_checker u_hhyo_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .mode     (mode),
  .out_valid(out_valid),
  .out_ready(out_ready)
);

### tb/sv/heading_history_yaw_offset_core_test.sv
module heading_history_yaw_offset_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hhyo_pkg::*;

  localparam int DEPTH = 64;
  localparam int RING_LAST = DEPTH - 1;
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [THR_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic mode;
  logic [TIME_W-1:0] time_ms;
  logic signed [ANG_W-1:0] yaw_cdeg;
  logic signed [ANG_W-1:0] gimbal_yaw_cdeg;
  logic out_valid;
  logic out_ready;
  logic [TIME_W-1:0] query_time_ms;
  logic signed [HDG_W-1:0] offset_cdeg;

  typedef struct packed {
    logic [TIME_W-1:0] qtime;
    logic signed [HDG_W-1:0] offset;
  } offset_item_t;

  // predictor copy of the block state
  logic [TIME_W-1:0] hist_time [DEPTH];
  logic [HDG_W-1:0] hist_heading [DEPTH];
  int newest;
  bit started;
  logic [THR_W-1:0] threshold;

  offset_item_t pending_offsets[$];
  int errors;
  int items_sent;
  int offsets_checked;
  longint cycles;
  bit stall_enable;
  logic [TIME_W-1:0] clock_ms;

  heading_history_yaw_offset_core #(.HISTORY_DEPTH(DEPTH)) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .time_ms(time_ms),
    .yaw_cdeg(yaw_cdeg),
    .gimbal_yaw_cdeg(gimbal_yaw_cdeg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .query_time_ms(query_time_ms),
    .offset_cdeg(offset_cdeg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint wrap_turn(longint a);
    longint r;
    r = a % 36000;
    if (r < 0) r += 36000;
    return r;
  endfunction

  function automatic int ring_prev(int i);
    return (i == 0) ? RING_LAST : i - 1;
  endfunction

  function automatic int ring_next(int i);
    return (i == RING_LAST) ? 0 : i + 1;
  endfunction

  // update history and compute the expected offset for one item
  task automatic predict_offset(logic m, logic [TIME_W-1:0] t, logic signed [ANG_W-1:0] y,
                                logic signed [ANG_W-1:0] g);
    int idx;
    int prior;
    int later;
    int oldest;
    longint lag;
    longint span;
    longint hdg;
    longint arc;
    longint off;
    offset_item_t e;
    if (m == MODE_RECORD) begin
      hdg = wrap_turn(longint'(y) + longint'(g));
      newest = started ? ring_next(newest) : 1;
      started = 1'b1;
      hist_time[newest] = t;
      hist_heading[newest] = HDG_W'(hdg);
      return;
    end
    if (!started) return;
    idx = newest;
    prior = idx;
    lag = longint'(t) - longint'(hist_time[idx]);
    if (lag < 0) begin
      oldest = ring_next(newest);
      while (idx != oldest) begin
        idx = ring_prev(idx);
        if (hist_time[idx] == 0) break;
        prior = idx;
        lag = longint'(t) - longint'(hist_time[idx]);
        if (lag >= 0) break;
      end
      if (lag < 0) lag = 0;
    end
    hdg = hist_heading[prior];
    if (lag >= longint'(threshold) && idx != newest) begin
      later = ring_next(idx);
      span = longint'(hist_time[later]) - longint'(hist_time[prior]);
      if (span > 0 && lag <= span) begin
        arc = longint'(hist_heading[later]) - hdg;
        if (arc < 0) arc += 36000;
        if (arc <= 18000) hdg += (lag * arc) / span;
        else hdg -= (lag * (36000 - arc)) / span;
        hdg = wrap_turn(hdg);
      end
    end
    off = wrap_turn(longint'(y) - hdg);
    if (off > 18000) off -= 36000;
    e.qtime = t;
    e.offset = HDG_W'(off);
    pending_offsets.push_back(e);
  endtask

  // send one item, then idle for a random gap now and then
  task automatic send_item(logic m, logic [TIME_W-1:0] t, logic signed [ANG_W-1:0] y,
                           logic signed [ANG_W-1:0] g);
    in_valid <= 1'b1;
    mode <= m;
    time_ms <= t;
    yaw_cdeg <= y;
    gimbal_yaw_cdeg <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_offset(m, t, y, g);
    items_sent++;
    if (stall_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_offsets();
    while (pending_offsets.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 40) @(posedge clk);
  endtask

  // write the threshold while the block is idle
  task automatic set_threshold(logic [THR_W-1:0] v);
    in_valid <= 1'b0;
    drain_offsets();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold = v;
  endtask

  function automatic logic signed [ANG_W-1:0] rand_angle();
    return ANG_W'($urandom_range(0, 53999)) - ANG_W'(18000);
  endfunction

  task automatic test_before_record();
    send_item(MODE_QUERY, 48'd500, 17'sd100, 17'sd0);
    send_item(MODE_QUERY, '1, -17'sd18000, 17'sd35999);
  endtask

  task automatic test_directed();
    send_item(MODE_RECORD, 48'd0, 17'sd35999, 17'sd35999);
    send_item(MODE_QUERY, 48'd0, -17'sd18000, 17'sd0);
    send_item(MODE_RECORD, 48'd1000, -17'sd18000, -17'sd18000);
    send_item(MODE_RECORD, 48'd1100, 17'sd1000, 17'sd0);
    send_item(MODE_RECORD, 48'd1100, 17'sd9000, 17'sd0);
    send_item(MODE_RECORD, 48'd1300, 17'sd35000, 17'sd0);
    send_item(MODE_QUERY, 48'd1050, 17'sd0, 17'sd0);
    send_item(MODE_QUERY, 48'd1100, 17'sd0, 17'sd0);
    send_item(MODE_QUERY, 48'd1250, 17'sd35999, 17'sd0);
    send_item(MODE_QUERY, 48'd1305, 17'sd17999, 17'sd0);
    send_item(MODE_QUERY, 48'd5, 17'sd100, 17'sd0);
    send_item(MODE_QUERY, 48'd1110, 17'sd35999, 17'sd0);
    send_item(MODE_QUERY, '1, 17'sd0, 17'sd0);
    send_item(MODE_RECORD, '1, 17'sd12345, 17'sd23456);
    send_item(MODE_QUERY, 48'h7FFF_FFFF_FFFF, 17'sd5, 17'sd0);
  endtask

  task automatic test_threshold_extremes();
    set_threshold(16'd0);
    send_item(MODE_QUERY, 48'd1050, 17'sd0, 17'sd0);
    send_item(MODE_QUERY, 48'd1101, 17'sd0, 17'sd0);
    set_threshold(16'hFFFF);
    send_item(MODE_QUERY, 48'd1250, 17'sd0, 17'sd0);
    set_threshold(16'd1);
    send_item(MODE_QUERY, 48'd1001, 17'sd0, 17'sd0);
  endtask

  // mostly steadily advancing records with queries trailing them
  task automatic test_random(int count, logic [THR_W-1:0] thr);
    int k;
    logic [TIME_W-1:0] t;
    set_threshold(thr);
    for (k = 0; k < count; k++) begin
      if (k == count / 2) begin
        in_valid <= 1'b0;
        drain_offsets();
      end
      case ($urandom_range(0, 9))
        0: begin
          t = TIME_W'({$urandom(), $urandom()});
          send_item(logic'($urandom_range(0, 1)), t, rand_angle(), rand_angle());
        end
        1, 2, 3, 4: begin
          clock_ms += TIME_W'($urandom_range(0, 80));
          send_item(MODE_RECORD, clock_ms, rand_angle(), rand_angle());
        end
        default: begin
          t = clock_ms - TIME_W'($urandom_range(0, 3000)) + TIME_W'($urandom_range(0, 40));
          send_item(MODE_QUERY, t, rand_angle(), rand_angle());
        end
      endcase
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (cycles % 512 < 160) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // compare each accepted offset with the oldest expectation
  always @(posedge clk) begin
    offset_item_t e;
    cycles++;
    if (!rst && out_valid && out_ready) begin
      if (pending_offsets.size() == 0) begin
        $error("unexpected offset item: query_time_ms %0d offset_cdeg %0d",
               query_time_ms, offset_cdeg);
        errors++;
      end else begin
        e = pending_offsets.pop_front();
        offsets_checked++;
        if (query_time_ms !== e.qtime) begin
          $error("query_time_ms: expected %0d actual %0d", e.qtime, query_time_ms);
          errors++;
        end
        if (offset_cdeg !== e.offset) begin
          $error("offset_cdeg: expected %0d actual %0d", e.offset, offset_cdeg);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int i;
    errors = 0;
    items_sent = 0;
    offsets_checked = 0;
    cycles = 0;
    stall_enable = 1'b0;
    clock_ms = 48'd10000;
    for (i = 0; i < DEPTH; i++) begin
      hist_time[i] = '0;
      hist_heading[i] = '0;
    end
    newest = 0;
    started = 1'b0;
    threshold = THR_RESET;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    mode <= 1'b0;
    time_ms <= '0;
    yaw_cdeg <= '0;
    gimbal_yaw_cdeg <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_record();
    test_directed();
    test_threshold_extremes();
    stall_enable = 1'b1;
    test_random(300, 16'd20);
    test_random(300, 16'd5);
    test_random(300, 16'hFFFF);
    in_valid <= 1'b0;
    drain_offsets();
    $display("Sent %0d items (records and queries), checked %0d offset items", items_sent,
             offsets_checked);
    $display("Threshold settings covered: 0, 1, 5, 20 and 65535");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hhyo_pkg.sv
rtl/hhyo_ram.sv
rtl/hhyo_div.sv
rtl/heading_history_yaw_offset_core.sv
rtl/hhyo_checker.sv
tb/sv/heading_history_yaw_offset_core_test.sv
